>>> design/msh_pkg.sv
`default_nettype none

package msh_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned MULT_W = 16;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned ADDR_W = 3;

  localparam logic [HASH_W-1:0] FOLD_LIMIT = 32'd16711661;
  localparam logic [DATA_W-1:0] PAD_VALUE  = 8'd137;
  localparam logic [MULT_W-1:0] MULT_RESET = 16'd257;
  localparam logic [HASH_W-1:0] SEED_RESET = 32'd0;
  localparam logic [CNT_W-1:0]  MIN_ROUNDS = 3'd6;

  // register index, taken from paddr[2]
  localparam logic REG_SEED = 1'b0;
  localparam logic REG_MULT = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_BYTE_LAST,
    KIND_END
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    state_e           state;
    logic [CNT_W-1:0] cnt;
    logic             q_pop;
  } back_status_t;

endpackage

`default_nettype wire

>>> design/msh_front.sv
`default_nettype none

module msh_front (
  input  wire logic                       push_i,
  input  wire logic                       q_full_i,
  input  wire logic [msh_pkg::DATA_W-1:0] data_byte_i,
  input  wire logic                       has_byte_i,
  input  wire logic                       is_last_i,
  output logic                            q_wr_o,
  output msh_pkg::entry_t                 q_entry_o
);
  import msh_pkg::*;

  logic accept;
  logic keep;
  kind_e kind;

  assign accept = push_i & ~q_full_i;

  // words with neither a byte nor an end mark are dropped here
  always_comb begin
    keep = 1'b1;
    kind = KIND_BYTE;
    unique case ({has_byte_i, is_last_i})
      2'b10: kind = KIND_BYTE;
      2'b11: kind = KIND_BYTE_LAST;
      2'b01: kind = KIND_END;
      default: keep = 1'b0;
    endcase
  end

  assign q_wr_o         = accept & keep;
  assign q_entry_o.kind = kind;
  assign q_entry_o.data = data_byte_i;

endmodule

`default_nettype wire

>>> design/msh_queue.sv
`default_nettype none

module msh_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       wr_i,
  input  msh_pkg::entry_t wr_entry_i,
  input  wire logic       rd_i,
  output msh_pkg::entry_t rd_entry_o,
  output logic            full_o,
  output logic            empty_o
);
  import msh_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

endmodule

`default_nettype wire

>>> design/msh_back.sv
`default_nettype none

module msh_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [msh_pkg::HASH_W-1:0] seed_i,
  input  wire logic [msh_pkg::MULT_W-1:0] mult_i,
  input  wire logic                       q_empty_i,
  input  msh_pkg::entry_t                 q_entry_i,
  output logic                            q_pop_o,
  input  wire logic                       pop_i,
  output logic                            empty_o,
  output logic [msh_pkg::HASH_W-1:0]      hash_value_o,
  output msh_pkg::back_status_t           status_o
);
  import msh_pkg::*;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
  logic                last_q, last_d;
  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic [HASH_W-1:0]   fold_q, fold_d;
  logic [HASH_W-1:0]   sum_q;
  logic [HASH_W-1:0]   hash_q;
  logic [HASH_W-1:0]   base, raw;
  logic [HASH_W+MULT_W-1:0] prod;
  logic                slot_free;
  logic                q_pop;
  logic                val_load;
  logic                out_load;

  // first round of a name starts from the seed
  assign base    = (cnt_q == '0) ? seed_i : sum_q;
  assign raw     = base + HASH_W'(val_q);
  assign fold_d  = (raw > FOLD_LIMIT) ? raw - FOLD_LIMIT : raw;
  assign prod    = (HASH_W + MULT_W)'(fold_q) * (HASH_W + MULT_W)'(mult_i);
  assign cnt_inc = (cnt_q < MIN_ROUNDS) ? cnt_q + 1'b1 : cnt_q;
  assign slot_free = ~out_valid_q | pop_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_entry_i.kind == KIND_END && cnt_q >= MIN_ROUNDS) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_ADD;
          end
        end
      end
      ST_ADD: state_d = ST_MUL;
      ST_MUL: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (cnt_inc < MIN_ROUNDS) begin
          state_d = ST_ADD;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and register loads
  always_comb begin
    q_pop    = 1'b0;
    val_load = 1'b0;
    val_d    = PAD_VALUE;
    last_d   = last_q;
    cnt_d    = cnt_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop    = 1'b1;
          val_load = 1'b1;
          last_d   = (q_entry_i.kind != KIND_BYTE);
          if (q_entry_i.kind != KIND_END) begin
            val_d = q_entry_i.data;
          end
        end
      end
      ST_ADD: ;
      ST_MUL: begin
        cnt_d    = cnt_inc;
        val_load = 1'b1;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          cnt_d    = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (val_load) begin
      val_q <= val_d;
    end
    if (state_q == ST_ADD) begin
      fold_q <= fold_d;
    end
    if (state_q == ST_MUL) begin
      sum_q <= prod[HASH_W-1:0];
    end
    if (out_load) begin
      hash_q <= sum_q;
    end
  end

  assign q_pop_o        = q_pop;
  assign empty_o        = ~out_valid_q;
  assign hash_value_o   = hash_q;
  assign status_o.state = state_q;
  assign status_o.cnt   = cnt_q;
  assign status_o.q_pop = q_pop;

endmodule

`default_nettype wire

>>> design/multiplicative_string_hash_unit.sv
// Channel  | Direction | Handshake       | Payload
// ---------+-----------+-----------------+------------------------------------------
// input    | in        | push / full     | data_byte_i, has_byte_i, is_last_i
// result   | out       | pop / empty     | hash_value_o
// config   | in        | APB psel/penable| seed @0x0 (32b), multiplier @0x4 (16b)
//
// Steps: each byte word is dequeued, added/folded and multiplied 32x16; short names
//   get pad rounds of add/fold and multiply, and an emit step moves each hash to
//   the result register. Idle words (no byte, no end mark) are dropped at the front.
// The input queue (QUEUE_DEPTH words) absorbs bursts; full rises when it fills.
// Reset: queue empty, no result pending, seed 0, multiplier 257.
// A held result (pop low) stalls only the engine, the queue keeps filling.
`default_nettype none

module multiplicative_string_hash_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input word channel
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [msh_pkg::DATA_W-1:0] data_byte_i,
  input  wire logic                       has_byte_i,
  input  wire logic                       is_last_i,
  // result channel
  input  wire logic                       pop,
  output logic                            empty,
  output logic [msh_pkg::HASH_W-1:0]      hash_value_o,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [msh_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import msh_pkg::*;

  logic [HASH_W-1:0] seed_q;
  logic [MULT_W-1:0] mult_q;
  logic              cfg_wr;
  logic              reg_sel;

  logic              q_wr;
  entry_t            q_wr_entry;
  logic              q_rd;
  entry_t            q_rd_entry;
  logic              q_full;
  logic              q_empty;
  back_status_t      back_st;

  // ---------------------------------------------------------------------
  // Configuration registers; writes land in the APB access phase
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SEED_RESET;
      mult_q <= MULT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SEED: seed_q <= pwdata;
        REG_MULT: mult_q <= pwdata[MULT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_SEED: prdata = seed_q;
      REG_MULT: prdata = {{(32 - MULT_W){1'b0}}, mult_q};
      default: prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Front: accept and sort input words
  // ---------------------------------------------------------------------
  assign full = q_full;

  msh_front u_front (
    .push_i      (push),
    .q_full_i    (q_full),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .is_last_i   (is_last_i),
    .q_wr_o      (q_wr),
    .q_entry_o   (q_wr_entry)
  );

  // ---------------------------------------------------------------------
  // Queue between front and round engine
  // ---------------------------------------------------------------------
  msh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_wr),
    .wr_entry_i (q_wr_entry),
    .rd_i       (q_rd),
    .rd_entry_o (q_rd_entry),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // ---------------------------------------------------------------------
  // Back: round engine plus result register
  // ---------------------------------------------------------------------
  msh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_q),
    .mult_i       (mult_q),
    .q_empty_i    (q_empty),
    .q_entry_i    (q_rd_entry),
    .q_pop_o      (q_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .hash_value_o (hash_value_o),
    .status_o     (back_st)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_wr)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.q_pop |-> !q_empty)
    else $error("engine took a word from an empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.cnt <= MIN_ROUNDS)
    else $error("round count past its limit");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> $past(back_st.state == ST_EMIT))
    else $error("result appeared outside the emit step");

endmodule

`default_nettype wire
